/* hdl/rdq_pkg.sv */
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared types, sizes and codes for the ring deque.
// ----------------------------------------------------------------------------
package rdq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W     = $clog2(2 * DEPTH);
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned ENTRIES_W = 5;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [SUM_W-1:0]          sum_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [ENTRIES_W-1:0]      entries_t;

  typedef enum logic [1:0] {
    OP_APPEND      = 2'd0,
    OP_REMOVE_HEAD = 2'd1,
    OP_REMOVE_TAIL = 2'd2,
    OP_DISPLAY     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Request from the sequencer to the entry memory
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    value_t wdata;
    logic   re;
    idx_t   raddr;
  } ram_req_t;

  // Ring wrap of a sum below twice the depth
  function automatic idx_t wrap(input sum_t s);
    sum_t r;
    r = (s >= sum_t'(DEPTH)) ? s - sum_t'(DEPTH) : s;
    return r[IDX_W-1:0];
  endfunction

endpackage

/* hdl/rdq_cmd_if.sv */
// ----------------------------------------------------------------------------
// rdq_cmd_if
// Command channel: opcode and value with valid/ready.
// ----------------------------------------------------------------------------
interface rdq_cmd_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  rdq_pkg::value_t      value_in;

  modport source (output valid, output opcode, output value_in, input ready);
  modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

/* hdl/rdq_res_if.sv */
// ----------------------------------------------------------------------------
// rdq_res_if
// Result channel: value, status, entry count and end marker with valid/ready.
// ----------------------------------------------------------------------------
interface rdq_res_if;
  logic                 valid;
  logic                 ready;
  rdq_pkg::value_t      value_out;
  logic [1:0]           status;
  rdq_pkg::entries_t    entries_now;
  logic                 last_of_run;

  modport source (output valid, output value_out, output status, output entries_now,
                  output last_of_run, input ready);
  modport sink   (input valid, input value_out, input status, input entries_now,
                  input last_of_run, output ready);
endinterface

/* hdl/rdq_ram.sv */
// ----------------------------------------------------------------------------
// rdq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/rdq_ctrl.sv */
// ----------------------------------------------------------------------------
// rdq_ctrl
// Command sequencer: head/count registers, memory requests, result register.
// ----------------------------------------------------------------------------
module rdq_ctrl (
  input  logic                clk,
  input  logic                rst,
  rdq_cmd_if.sink             cmd,
  rdq_res_if.source           res,
  output rdq_pkg::ram_req_t   ram_req,
  input  rdq_pkg::value_t     ram_rdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_DISP = 4'b1000
  } state_t;

  state_t             state, state_next;
  rdq_pkg::idx_t      head, head_next;
  rdq_pkg::cnt_t      count, count_next;
  rdq_pkg::cnt_t      disp_idx, disp_idx_next;
  rdq_pkg::opcode_t   op;
  rdq_pkg::value_t    val;

  logic               out_free;
  logic               out_load;
  rdq_pkg::value_t    out_value;
  rdq_pkg::status_t   out_status;
  logic               out_last;
  logic               out_valid;

  assign out_free  = !out_valid || res.ready;
  assign cmd.ready = (state == S_IDLE);
  assign res.valid = out_valid;

  always_comb begin
    state_next    = state;
    head_next     = head;
    count_next    = count;
    disp_idx_next = disp_idx;
    ram_req       = '0;
    out_load      = 1'b0;
    out_value     = '0;
    out_status    = rdq_pkg::ST_OK;
    out_last      = 1'b1;

    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          if (op == rdq_pkg::OP_APPEND) begin
            out_load   = 1'b1;
            state_next = S_IDLE;
            if (count == rdq_pkg::cnt_t'(rdq_pkg::DEPTH)) begin
              out_status = rdq_pkg::ST_FULL;
            end else begin
              ram_req.we    = 1'b1;
              ram_req.waddr = rdq_pkg::wrap(rdq_pkg::sum_t'(head) + rdq_pkg::sum_t'(count));
              ram_req.wdata = val;
              count_next    = count + rdq_pkg::cnt_t'(1);
            end
          end else if (count == '0) begin
            out_load   = 1'b1;
            out_status = rdq_pkg::ST_EMPTY;
            state_next = S_IDLE;
          end else begin
            ram_req.re = 1'b1;
            case (op)
              rdq_pkg::OP_REMOVE_HEAD: begin
                ram_req.raddr = head;
                head_next     = rdq_pkg::wrap(rdq_pkg::sum_t'(head) + rdq_pkg::sum_t'(1));
                count_next    = count - rdq_pkg::cnt_t'(1);
                state_next    = S_READ;
              end
              rdq_pkg::OP_REMOVE_TAIL: begin
                ram_req.raddr = rdq_pkg::wrap(rdq_pkg::sum_t'(head) + rdq_pkg::sum_t'(count)
                                              - rdq_pkg::sum_t'(1));
                count_next    = count - rdq_pkg::cnt_t'(1);
                state_next    = S_READ;
              end
              default: begin
                ram_req.raddr = head;
                disp_idx_next = rdq_pkg::cnt_t'(1);
                state_next    = S_DISP;
              end
            endcase
          end
        end
      end

      S_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_value  = ram_rdata;
          state_next = S_IDLE;
        end
      end

      S_DISP: begin
        // disp_idx is the position after the entry now in ram_rdata
        if (out_free) begin
          out_load  = 1'b1;
          out_value = ram_rdata;
          out_last  = (disp_idx == count);
          if (disp_idx == count) begin
            state_next = S_IDLE;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = rdq_pkg::wrap(rdq_pkg::sum_t'(head) + rdq_pkg::sum_t'(disp_idx));
            disp_idx_next = disp_idx + rdq_pkg::cnt_t'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      disp_idx <= '0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      count    <= count_next;
      disp_idx <= disp_idx_next;
    end
  end

  // latched command
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op  <= rdq_pkg::opcode_t'(cmd.opcode);
      val <= cmd.value_in;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.value_out   <= out_value;
      res.status      <= out_status;
      res.entries_now <= rdq_pkg::ENTRIES_W'(count_next);
      res.last_of_run <= out_last;
    end
  end

endmodule

/* hdl/ring_deque_tail_push_pop_both.sv */
// ----------------------------------------------------------------------------
// ring_deque_tail_push_pop_both
// Bounded deque of signed 32-bit values held in a ring memory.
// ----------------------------------------------------------------------------
// Usage:
//  - cmd carries one command transaction: opcode (append at tail, remove head,
//    remove tail, display) and value_in (used by append only).
//  - res carries result transactions: value_out, status (ok, empty, full),
//    entries_now after the command, and last_of_run on the final result of
//    each command. Every command gives exactly one result, except a display
//    of a non-empty list, which gives one per entry, first to last.
//  - Append and empty/full outcomes load their result from the command state;
//    removes and the first display result first pass through the registered
//    read port of the entry memory.
//  - Commands are taken one at a time, only while the sequencer is idle;
//    display streams one entry per cycle, unless res stalls, through the
//    single memory read port.
//  - Results sit in an output register, so the next command is taken while a
//    result waits; a stall on res holds the sequencer only when it has a new
//    result to load.
//  - Synchronous reset empties the list (head and count to zero) and drops
//    any pending result. Memory contents are not cleared; only written
//    entries are ever read.
// ----------------------------------------------------------------------------
module ring_deque_tail_push_pop_both (
  input  logic      clk,
  input  logic      rst,
  rdq_cmd_if.sink   cmd,
  rdq_res_if.source res
);

  rdq_pkg::ram_req_t ram_req;
  rdq_pkg::value_t   ram_rdata;

  rdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  rdq_ram #(
    .WIDTH (rdq_pkg::VALUE_W),
    .DEPTH (rdq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ring deque. A local copy of the ring, head and
// count predicts the results of every command. Directed tests cover the empty
// list, wrap-around, fill and overflow. Random traffic then swings between
// filling and draining, with bursty stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import rdq_pkg::*;

  // One result transaction as the bench expects to see it
  typedef struct {
    value_t   value;
    status_t  status;
    entries_t entries;
    logic     last;
  } deque_result_t;

  logic clk;
  logic rst;

  rdq_cmd_if cmd_ch ();
  rdq_res_if res_ch ();

  ring_deque_tail_push_pop_both dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Local image of the deque: ring contents, head slot and live count
  value_t        ring_copy [DEPTH];
  int            ring_head;
  int            ring_count;
  deque_result_t awaited_results [$];

  int errors;
  bit bursty;      // random idle bursts on both channels when set
  int stall_left;  // cycles of the current ready-low burst still to run

  // --------------------------------------------------------------------------
  // Clock and one-off reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Every DUT input known from time zero
  initial begin
    rst             = 1'b1;
    cmd_ch.valid    = 1'b0;
    cmd_ch.opcode   = OP_APPEND;
    cmd_ch.value_in = '0;
    res_ch.ready    = 1'b0;
  end

  // Watchdog: generous bound over the slowest legal run
  initial begin
    #(12 * 200000);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction: applies one command to the local image and queues the
  // result transactions it must produce.
  // --------------------------------------------------------------------------
  function automatic void compute_deque_results(input opcode_t op, input value_t v);
    deque_result_t r;
    int i;
    r.value  = '0;
    r.status = ST_OK;
    r.last   = 1'b1;
    if (op == OP_APPEND) begin
      if (ring_count >= DEPTH) begin
        // full: value dropped, state untouched
        r.status = ST_FULL;
      end else begin
        ring_copy[(ring_head + ring_count) % DEPTH] = v;
        ring_count++;
      end
      r.entries = entries_t'(ring_count);
      awaited_results.push_back(r);
    end else if (ring_count == 0) begin
      // remove or display on an empty list
      r.status  = ST_EMPTY;
      r.entries = '0;
      awaited_results.push_back(r);
    end else if (op == OP_REMOVE_HEAD) begin
      r.value   = ring_copy[ring_head];
      ring_head = (ring_head + 1) % DEPTH;
      ring_count--;
      r.entries = entries_t'(ring_count);
      awaited_results.push_back(r);
    end else if (op == OP_REMOVE_TAIL) begin
      // head stays put; only the count shrinks
      r.value = ring_copy[(ring_head + ring_count - 1) % DEPTH];
      ring_count--;
      r.entries = entries_t'(ring_count);
      awaited_results.push_back(r);
    end else begin
      // display: one transaction per entry, first to last
      r.entries = entries_t'(ring_count);
      for (i = 0; i < ring_count; i++) begin
        r.value = ring_copy[(ring_head + i) % DEPTH];
        r.last  = (i == ring_count - 1);
        awaited_results.push_back(r);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random ready bursts and field-by-field comparison against
  // the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    deque_result_t exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual value %0d status %0d",
                 $time, res_ch.value_out, res_ch.status);
      end else begin
        exp_r = awaited_results.pop_front();
        if (res_ch.value_out !== exp_r.value) begin
          errors++;
          $display("%0t: value_out mismatch: expected %0d, actual %0d",
                   $time, exp_r.value, res_ch.value_out);
        end
        if (res_ch.status !== exp_r.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, exp_r.status, res_ch.status);
        end
        if (res_ch.entries_now !== exp_r.entries) begin
          errors++;
          $display("%0t: entries_now mismatch: expected %0d, actual %0d",
                   $time, exp_r.entries, res_ch.entries_now);
        end
        if (res_ch.last_of_run !== exp_r.last) begin
          errors++;
          $display("%0t: last_of_run mismatch: expected %0d, actual %0d",
                   $time, exp_r.last, res_ch.last_of_run);
        end
      end
    end
    // Back-pressure in bursts, started at random while bursty is set
    if (stall_left == 0 && bursty && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 8);
    if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      res_ch.ready <= !rst;
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // Offers one command transaction and returns once it has been taken.
  // valid stays high between back-to-back commands.
  task automatic send_cmd(input opcode_t op, input value_t v);
    int gap;
    if (bursty && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    compute_deque_results(op, v);
    cmd_ch.valid    <= 1'b1;
    cmd_ch.opcode   <= op;
    cmd_ch.value_in <= v;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Holds off the sender until every outstanding result has come back
  task automatic wait_for_drain();
    cmd_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Mostly full-range random words, now and then an extreme
  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Empty-list answers and removal of the only entry, from either end
  task automatic test_empty_list();
    send_cmd(OP_REMOVE_HEAD, value_t'($urandom));
    send_cmd(OP_APPEND, 32'sh8000_0000);
    send_cmd(OP_REMOVE_HEAD, '0);  // last entry gone via head
    send_cmd(OP_DISPLAY, value_t'($urandom));
    send_cmd(OP_APPEND, 32'sh7FFF_FFFF);
    send_cmd(OP_REMOVE_TAIL, '0);  // last entry gone via tail
    send_cmd(OP_REMOVE_TAIL, '0);
  endtask

  // Fill across the ring wrap, overflow once, then show the full list
  task automatic test_fill_and_overflow();
    int i;
    send_cmd(OP_APPEND, 32'sh8000_0000);
    send_cmd(OP_APPEND, 32'sh7FFF_FFFF);
    send_cmd(OP_APPEND, '0);
    send_cmd(OP_APPEND, -32'sd1);
    for (i = 4; i < DEPTH; i++)
      send_cmd(OP_APPEND, value_t'($urandom));
    send_cmd(OP_APPEND, 32'sh5A5A_A5A5);  // dropped
    send_cmd(OP_DISPLAY, '0);
  endtask

  // Random traffic that swings between filling up and draining out, so the
  // list spends time at every depth including both ends
  task automatic test_random_traffic(input int n_cmds);
    int    k;
    int    r;
    bit    filling;
    opcode_t op;
    filling = (ring_count < DEPTH / 2);
    for (k = 0; k < n_cmds; k++) begin
      if (ring_count >= DEPTH) filling = 1'b0;
      if (ring_count == 0)     filling = 1'b1;
      r = $urandom_range(0, 99);
      if (filling)
        op = (r < 60) ? OP_APPEND : (r < 76) ? OP_REMOVE_HEAD :
             (r < 92) ? OP_REMOVE_TAIL : OP_DISPLAY;
      else
        op = (r < 25) ? OP_APPEND : (r < 57) ? OP_REMOVE_HEAD :
             (r < 90) ? OP_REMOVE_TAIL : OP_DISPLAY;
      send_cmd(op, pick_value());
      // one full drain in the middle of the run
      if (k == n_cmds / 2) wait_for_drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    errors     = 0;
    bursty     = 1'b0;
    stall_left = 0;
    ring_head  = 0;
    ring_count = 0;
    foreach (ring_copy[i]) ring_copy[i] = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    bursty = 1'b1;
    test_fill_and_overflow();
    wait_for_drain();

    test_random_traffic(155);

    // closing stretch: no idling on either side
    bursty = 1'b0;
    test_random_traffic(30);

    wait_for_drain();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
